[hw/rtl/rrvg_pkg.sv]
`timescale 1ns / 1ps

package rrvg_pkg;

   // Default parameter values
   localparam int MAX_POINTS_PER_CORNER_DEF = 256;
   localparam int CORDIC_STEPS_DEF          = 16;

   // Fixed field widths
   localparam int CSR_DATA_W  = 16;
   localparam int PPC_W       = 9;
   localparam int INDEX_W     = 10;
   localparam int COORD_W     = 18;

   // Angle and CORDIC constants
   localparam int PHI_W                     = 17;       // phi < pi/2 * 2^16
   localparam logic [PHI_W-1:0] HALF_PI_Q16 = 17'd102944;
   localparam int CORDIC_XY_W               = 18;
   localparam int CORDIC_Z_W                = 20;
   localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN_Q15 = 18'sd19898;
   localparam logic signed [CORDIC_XY_W-1:0] Q15_MAX = 18'sd32767;
   localparam logic signed [CORDIC_XY_W-1:0] Q15_MIN = -18'sd32768;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] WIDTH_RST  = 16'd4800;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RST = 16'd960;
   localparam logic [CSR_DATA_W-1:0] RADIUS_RST = 16'd160;
   localparam logic [PPC_W-1:0]      PPC_RST    = 9'd8;

   // Register map
   typedef enum logic [1:0] {
      REG_SHAPE_WIDTH       = 2'd0,
      REG_SHAPE_HEIGHT      = 2'd1,
      REG_CORNER_RADIUS     = 2'd2,
      REG_POINTS_PER_CORNER = 2'd3
   } csr_index_type;

   // Sideband that travels with each beat
   typedef struct packed {
      logic       oor;
      logic [1:0] corner;
      logic [1:0] quad;
   } side_type;

   // round(atan(2^-i) * 2^16)
   function automatic logic [PHI_W-1:0] atan_q16(input int i);
      logic [PHI_W-1:0] v;
      case (i)
         0:       v = 17'd51472;
         1:       v = 17'd30385;
         2:       v = 17'd16055;
         3:       v = 17'd8150;
         4:       v = 17'd4091;
         5:       v = 17'd2047;
         6:       v = 17'd1024;
         7:       v = 17'd512;
         8:       v = 17'd256;
         9:       v = 17'd128;
         10:      v = 17'd64;
         11:      v = 17'd32;
         12:      v = 17'd16;
         13:      v = 17'd8;
         14:      v = 17'd4;
         15:      v = 17'd2;
         16:      v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/rounded_rectangle_vertex_generator_core.sv]
`timescale 1ns / 1ps

// Channel  | Signals                                        | Beat
// ---------+------------------------------------------------+-------------------------
// req      | req_valid, req_ready, req_point_index          | one vertex index
// rsp      | rsp_valid, rsp_ready, rsp_point_x/_y, _oor     | one vertex
// csr      | csr_write_enable, csr_index, csr_write_data    | one register write
//
// One index enters per cycle while rsp is not stalled; each passes through stages A and B, the divider
// seed, the bit-per-stage phase divider, the CORDIC chain and stages M, P and O.
// Reset (synchronous) clears all valid bits and loads register defaults.
// A stall on rsp freezes the whole pipeline; req_ready drops in the same cycle.
module rounded_rectangle_vertex_generator_core
   import rrvg_pkg::*;
#(
   parameter int MAX_POINTS_PER_CORNER = MAX_POINTS_PER_CORNER_DEF,
   parameter int CORDIC_STEPS          = CORDIC_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [INDEX_W-1:0]         req_point_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  rsp_point_x,
   output logic signed [COORD_W-1:0]  rsp_point_y,
   output logic                       rsp_index_out_of_range,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int CW = $clog2(MAX_POINTS_PER_CORNER + 1);   // count width
   localparam int DW = $clog2(MAX_POINTS_PER_CORNER);       // divisor width
   localparam int PW = (CW > PPC_W) ? CW : PPC_W;
   localparam int LW = (CW + 2 > INDEX_W) ? CW + 2 : INDEX_W;
   localparam int NW = DW + PHI_W;
   localparam int XW = CORDIC_XY_W;
   localparam int ZW = CORDIC_Z_W;
   localparam int CS = CORDIC_STEPS;

   // Configuration registers
   logic [CSR_DATA_W-1:0] width_ff, height_ff, radius_ff;
   logic [PPC_W-1:0]      ppc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         radius_ff <= RADIUS_RST;
         ppc_ff    <= PPC_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_SHAPE_WIDTH:       width_ff  <= csr_write_data;
            REG_SHAPE_HEIGHT:      height_ff <= csr_write_data;
            REG_CORNER_RADIUS:     radius_ff <= csr_write_data;
            REG_POINTS_PER_CORNER: ppc_ff    <= csr_write_data[PPC_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped count and divisor
   logic [PW-1:0] ppc_ext;
   logic [CW-1:0] cnt;
   logic [DW-1:0] dvs;

   always_comb begin
      ppc_ext = PW'(ppc_ff);
      if (ppc_ext < PW'(2))
         cnt = CW'(2);
      else if (ppc_ext > PW'(MAX_POINTS_PER_CORNER))
         cnt = CW'(MAX_POINTS_PER_CORNER);
      else
         cnt = CW'(ppc_ext);
      dvs = DW'(cnt - CW'(1));
   end

   // Global advance
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage A: corner, range check, m = index - corner
   logic [LW-1:0]      idx_l, cnt_l;
   logic               a_oor;
   logic [1:0]         a_corner;
   logic               a_v_ff;
   side_type           a_sd_ff;
   logic [INDEX_W-1:0] a_m_ff;

   always_comb begin
      idx_l    = LW'(req_point_index);
      cnt_l    = LW'(cnt);
      a_oor    = idx_l >= (cnt_l << 2);
      a_corner = 2'(idx_l >= cnt_l) + 2'(idx_l >= (cnt_l << 1))
               + 2'(idx_l >= (cnt_l + (cnt_l << 1)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sd_ff <= '{oor: a_oor, corner: a_corner, quad: 2'd0};
         a_m_ff  <= req_point_index - INDEX_W'(a_corner);
      end
   end

   // Stage B: quadrant and remainder by compare against multiples of d
   logic [LW-1:0] m_l, d1, d2, d3, d4, dsel;
   logic [2:0]    q_full;
   logic          b_v_ff;
   side_type      b_sd_ff;
   logic [DW-1:0] b_rr_ff;

   always_comb begin
      m_l    = LW'(a_m_ff);
      d1     = LW'(dvs);
      d2     = d1 << 1;
      d3     = d1 + d2;
      d4     = d1 << 2;
      q_full = 3'(m_l >= d1) + 3'(m_l >= d2) + 3'(m_l >= d3) + 3'(m_l >= d4);
      case (q_full)
         3'd1:    dsel = d1;
         3'd2:    dsel = d2;
         3'd3:    dsel = d3;
         3'd4:    dsel = d4;
         default: dsel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_sd_ff <= '{oor: a_sd_ff.oor, corner: a_sd_ff.corner, quad: q_full[1:0]};
         b_rr_ff <= DW'(m_l - dsel);
      end
   end

   // Stage C: phase numerator rr * pi/2 + d/2, loaded as divider seed
   logic [NW-1:0] num;
   assign num = NW'(b_rr_ff) * NW'(HALF_PI_Q16) + NW'(dvs >> 1);

   logic          dv_v_ff   [0:PHI_W];
   side_type      dv_sd_ff  [0:PHI_W];
   logic [DW-1:0] dv_rem_ff [0:PHI_W];
   logic [PHI_W-1:0] dv_low_ff [0:PHI_W];
   logic [PHI_W-1:0] dv_quo_ff [0:PHI_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_sd_ff[0]  <= b_sd_ff;
         dv_rem_ff[0] <= num[NW-1:PHI_W];
         dv_low_ff[0] <= num[PHI_W-1:0];
         dv_quo_ff[0] <= '0;
      end
   end

   // Restoring divider, one quotient bit per stage
   for (genvar k = 1; k <= PHI_W; k++) begin : g_div
      logic [DW:0]   trial;
      logic          take;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial  = {dv_rem_ff[k-1], dv_low_ff[k-1][PHI_W-1]};
         take   = trial >= {1'b0, dvs};
         rem_in = take ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_sd_ff[k]  <= dv_sd_ff[k-1];
            dv_rem_ff[k] <= rem_in;
            dv_low_ff[k] <= dv_low_ff[k-1] << 1;
            dv_quo_ff[k] <= {dv_quo_ff[k-1][PHI_W-2:0], take};
         end
      end
   end

   // CORDIC rotation, one iteration per stage
   logic                 cr_v_ff  [0:CS-1];
   side_type             cr_sd_ff [0:CS-1];
   logic signed [XW-1:0] cr_x_ff  [0:CS-1];
   logic signed [XW-1:0] cr_y_ff  [0:CS-1];
   logic signed [ZW-1:0] cr_z_ff  [0:CS-1];

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      logic                 v_prev;
      side_type             sd_prev;
      logic signed [XW-1:0] x_prev, y_prev, xs, ys;
      logic signed [ZW-1:0] z_prev, at;

      if (i == 0) begin : g_first
         assign v_prev  = dv_v_ff[PHI_W];
         assign sd_prev = dv_sd_ff[PHI_W];
         assign x_prev  = CORDIC_GAIN_Q15;
         assign y_prev  = '0;
         assign z_prev  = ZW'(dv_quo_ff[PHI_W]);
      end else begin : g_next
         assign v_prev  = cr_v_ff[i-1];
         assign sd_prev = cr_sd_ff[i-1];
         assign x_prev  = cr_x_ff[i-1];
         assign y_prev  = cr_y_ff[i-1];
         assign z_prev  = cr_z_ff[i-1];
      end

      always_comb begin
         xs = x_prev >>> i;
         ys = y_prev >>> i;
         at = ZW'(atan_q16(i));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cr_v_ff[i] <= 1'b0;
         end else if (adv) begin
            cr_v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cr_sd_ff[i] <= sd_prev;
            if (!z_prev[ZW-1]) begin
               cr_x_ff[i] <= x_prev - ys;
               cr_y_ff[i] <= y_prev + xs;
               cr_z_ff[i] <= z_prev - at;
            end else begin
               cr_x_ff[i] <= x_prev + ys;
               cr_y_ff[i] <= y_prev - xs;
               cr_z_ff[i] <= z_prev + at;
            end
         end
      end
   end

   // Stage M: clamp to Q1.15 and rotate by quadrant
   logic signed [XW-1:0] cl_c, cl_s;
   logic signed [16:0]   cv_in, sv_in;
   logic                 m_v_ff;
   side_type             m_sd_ff;
   logic signed [16:0]   m_cv_ff, m_sv_ff;

   always_comb begin
      cl_c = cr_x_ff[CS-1];
      cl_s = cr_y_ff[CS-1];
      if (cl_c > Q15_MAX) cl_c = Q15_MAX;
      if (cl_c < Q15_MIN) cl_c = Q15_MIN;
      if (cl_s > Q15_MAX) cl_s = Q15_MAX;
      if (cl_s < Q15_MIN) cl_s = Q15_MIN;
      case (cr_sd_ff[CS-1].quad)
         2'd0:    begin cv_in = 17'(cl_c);  sv_in = 17'(cl_s);  end
         2'd1:    begin cv_in = -17'(cl_s); sv_in = 17'(cl_c);  end
         2'd2:    begin cv_in = -17'(cl_c); sv_in = -17'(cl_s); end
         default: begin cv_in = 17'(cl_s);  sv_in = -17'(cl_c); end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= cr_v_ff[CS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_sd_ff <= cr_sd_ff[CS-1];
         m_cv_ff <= cv_in;
         m_sv_ff <= sv_in;
      end
   end

   // Stage P: radius products
   logic signed [16:0] r_s;
   logic               p_v_ff;
   side_type           p_sd_ff;
   logic signed [33:0] p_x_ff, p_y_ff;

   assign r_s = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_sd_ff <= m_sd_ff;
         p_x_ff  <= 34'(r_s) * 34'(m_cv_ff);
         p_y_ff  <= 34'(r_s) * 34'(m_sv_ff);
      end
   end

   // Stage O: round to Q.4, add centre, saturate
   logic signed [19:0] rx, ry, cxs, cys, px, py;
   logic signed [COORD_W-1:0] px_sat, py_sat;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic                      oor_ff;

   always_comb begin
      rx  = 20'((p_x_ff + 34'sd16384) >>> 15);
      ry  = 20'((p_y_ff + 34'sd16384) >>> 15);
      cxs = (p_sd_ff.corner == 2'd0 || p_sd_ff.corner == 2'd3)
          ? $signed({4'd0, width_ff}) - $signed({4'd0, radius_ff})
          : $signed({4'd0, radius_ff});
      cys = (p_sd_ff.corner <= 2'd1)
          ? $signed({4'd0, radius_ff})
          : $signed({4'd0, height_ff}) - $signed({4'd0, radius_ff});
      px  = cxs + rx;
      py  = cys - ry;
      if (px > 20'sd131071)       px_sat = 18'sd131071;
      else if (px < -20'sd131072) px_sat = -18'sd131072;
      else                        px_sat = 18'(px);
      if (py > 20'sd131071)       py_sat = 18'sd131071;
      else if (py < -20'sd131072) py_sat = -18'sd131072;
      else                        py_sat = 18'(py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor_ff <= p_sd_ff.oor;
         x_ff   <= p_sd_ff.oor ? '0 : px_sat;
         y_ff   <= p_sd_ff.oor ? '0 : py_sat;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_point_x            = x_ff;
   assign rsp_point_y            = y_ff;
   assign rsp_index_out_of_range = oor_ff;

   // Checks
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_out_of_range |-> rsp_point_x == '0 && rsp_point_y == '0)
      else $error("out-of-range beat with nonzero coordinates");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("pipeline stalled without output backpressure");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
